// ===== hdl/pst_pkg.sv =====
// ---------------------------------------------------------------------------
// pst_pkg: shared types and constants of the polyline stroke tessellator
// Command/status bundles, controller states, register indexes, helpers.
// ---------------------------------------------------------------------------
`default_nettype none
package pst_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 16;
  localparam int VNUM_W   = 6;
  localparam int BOX_W    = 12;
  localparam int LW_W     = 10;
  localparam int CFG_IDX_W = 2;

  // divider: dividend covers 2*16*(s-low)*uh + span, divisor 2*span
  localparam int DIV_NW = 35;
  localparam int DIV_DW = 18;

  // offset search: 10 result bits, 2k-1 on 11 bits
  localparam int K_W    = 10;
  localparam int T_W    = 11;
  localparam int T2_W   = 22;
  localparam int LEN2_W = 33;
  localparam int TGT_W  = 52;
  localparam int PROD_W = 55;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd2;

  localparam logic [BOX_W-1:0] PAD_X2 = 12'd4;   // 2 px each side
  localparam logic [BOX_W-1:0] PAD_Y2 = 12'd6;   // 3 px each side
  localparam logic [COORD_W-1:0] ORG_X = 16'd32; // 2 px in 1/16
  localparam int ORG_Y = 48;                     // 3 px in 1/16

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_XGO, ST_XWAIT, ST_YGO, ST_YWAIT, ST_PTWR,
    ST_RDA, ST_RDB, ST_RDI, ST_DIFF, ST_SQ, ST_LEN,
    ST_KT, ST_KM0, ST_KM1, ST_KCMP, ST_EMITP, ST_EMITM
  } pst_state_t;

  typedef enum logic [1:0] {RD_A, RD_B, RD_I} pst_rdsel_t;

  typedef struct packed {
    logic       load;
    logic       chk;
    logic       xdiv_go;
    logic       ydiv_go;
    logic       x_cap;
    logic       y_cap;
    logic       pt_wr;
    logic       idx_clr;
    logic       idx_inc;
    pst_rdsel_t rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_i;
    logic       sq;
    logic       len;
    logic       k_t;
    logic       k_m0;
    logic       k_m1;
    logic       k_cmp;
    logic       emit_p;
    logic       emit_m;
  } pst_cmd_t;

  typedef struct packed {
    logic n_ok;
    logic div_done;
    logic idx_last;
    logic bit_last;
    logic sel_y;
    logic out_free;
  } pst_stat_t;

  function automatic logic [COORD_W-1:0] sat16(input logic signed [17:0] v);
    logic [COORD_W-1:0] r;
    if (v > 18'sd32767) r = 16'h7FFF;
    else if (v < -18'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pst_div.sv =====
// ---------------------------------------------------------------------------
// pst_div: restoring divider, one quotient bit per cycle
// Quotient of num/den; done pulses for a single cycle with the last bit.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_div
  import pst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic                   done,
  output logic [DIV_NW-1:0]      quo
);
  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial;

  always_comb begin
    trial = {rem_r, quo_r[DIV_NW-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = DIV_DW'(trial - {1'b0, den_r});
      quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIV_DW-1:0];
      quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== hdl/pst_dp.sv =====
// ---------------------------------------------------------------------------
// pst_dp: datapath of the stroke tessellator
// Config registers, sample and point stores, fitting, offset search, output.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_dp
  import pst_pkg::*;
#(
  parameter int MAX_SAMPLES = 32
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pst_cmd_t              cmd_i,
  output pst_stat_t                  stat_o,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [BOX_W-1:0]      cfg_data,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  in_last,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [39:0]                out_tdata,
  output logic                       out_tlast
);
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  // configuration
  logic [BOX_W-1:0] bw_r, bh_r;
  logic [LW_W-1:0]  lw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= 12'd100;
      bh_r <= 12'd40;
      lw_r <= 10'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOX_WIDTH:  bw_r <= cfg_data;
        CFG_BOX_HEIGHT: bh_r <= cfg_data;
        CFG_LINE_WIDTH: lw_r <= cfg_data[LW_W-1:0];
        default: ;
      endcase
    end
  end

  // sample loading
  logic [CNT_W-1:0]           cnt_r, n_r;
  logic signed [SAMPLE_W-1:0] low_r, high_r;
  logic [SAMPLE_W-1:0]        sample_mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0]        sample_q;
  logic                       room;
  logic signed [SAMPLE_W-1:0] vin;

  assign room = cnt_r < CNT_W'(MAX_SAMPLES);
  assign vin  = $signed(in_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      n_r    <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else if (cmd_i.load) begin
      if (room) begin
        if (cnt_r == '0) begin
          low_r  <= vin;
          high_r <= vin;
        end else begin
          if (vin < low_r)  low_r  <= vin;
          if (vin > high_r) high_r <= vin;
        end
      end
      if (in_last) begin
        cnt_r <= '0;
        n_r   <= room ? cnt_r + CNT_W'(1) : cnt_r;
      end else if (room) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (cmd_i.load && room) sample_mem[cnt_r[IDX_W-1:0]] <= in_sample;
    sample_q <= sample_mem[idx_r];
  end

  // point index
  logic idx_last;
  assign idx_last = CNT_W'(idx_r) == CNT_W'(n_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (cmd_i.idx_clr) idx_r <= '0;
    else if (cmd_i.idx_inc) idx_r <= idx_r + IDX_W'(1);
  end

  // fitting
  logic [BOX_W-1:0]        uw, uh;
  logic signed [SAMPLE_W:0] hl;
  logic [SAMPLE_W-1:0]     span, sdiff;
  logic [IDX_W+BOX_W-1:0]  xprod;
  logic [SAMPLE_W+BOX_W-1:0] yprod;
  logic [DIV_NW-1:0]       dnum;
  logic [DIV_DW-1:0]       dden;
  logic                    div_done;
  logic [DIV_NW-1:0]       quo;
  logic [COORD_W-1:0]      x_r, y_r;

  assign uw    = (bw_r > PAD_X2) ? bw_r - PAD_X2 : 12'd1;
  assign uh    = (bh_r > PAD_Y2) ? bh_r - PAD_Y2 : 12'd1;
  assign hl    = {high_r[SAMPLE_W-1], high_r} - {low_r[SAMPLE_W-1], low_r};
  assign span  = (high_r > low_r) ? hl[SAMPLE_W-1:0] : 16'd1;
  assign sdiff = SAMPLE_W'(sample_q - low_r);
  assign xprod = idx_r * uw;
  assign yprod = sdiff * uh;

  always_comb begin
    if (cmd_i.xdiv_go) begin
      dnum = DIV_NW'({xprod, 5'b0}) + DIV_NW'(CNT_W'(n_r - CNT_W'(1)));
      dden = DIV_DW'({CNT_W'(n_r - CNT_W'(1)), 1'b0});
    end else begin
      dnum = DIV_NW'({yprod, 5'b0}) + DIV_NW'(span);
      dden = DIV_DW'({span, 1'b0});
    end
  end

  pst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd_i.xdiv_go | cmd_i.ydiv_go),
    .num   (dnum),
    .den   (dden),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd_i.x_cap) x_r <= quo[COORD_W-1:0] + ORG_X;
    if (cmd_i.y_cap) y_r <= COORD_W'(18'(ORG_Y) + 18'({uh, 4'b0}) - quo[17:0]);
  end

  // point store
  logic [2*COORD_W-1:0] point_mem [MAX_SAMPLES];
  logic [2*COORD_W-1:0] pt_q, pa_r, pb_r, pi_r;
  logic [IDX_W-1:0]     a_idx, b_idx, rd_addr;

  always_comb begin
    if (idx_r == '0) begin
      a_idx = '0;
      b_idx = IDX_W'(1);
    end else if (idx_last) begin
      a_idx = IDX_W'(n_r - CNT_W'(2));
      b_idx = IDX_W'(n_r - CNT_W'(1));
    end else begin
      a_idx = idx_r - IDX_W'(1);
      b_idx = idx_r + IDX_W'(1);
    end
    case (cmd_i.rd_sel)
      RD_A:    rd_addr = a_idx;
      RD_B:    rd_addr = b_idx;
      default: rd_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.pt_wr) point_mem[idx_r] <= {x_r, y_r};
    pt_q <= point_mem[rd_addr];
    if (cmd_i.cap_a) pa_r <= pt_q;
    if (cmd_i.cap_b) pb_r <= pt_q;
    if (cmd_i.cap_i) pi_r <= pt_q;
  end

  // direction and its squares
  logic signed [COORD_W:0] dx, dy, dxf;
  logic [COORD_W-1:0]      adx_r, ady_r;
  logic                    dxp_r, dxn_r, dyp_r, dyn_r;
  logic [2*COORD_W-1:0]    adx2_r, ady2_r;
  logic [COORD_W+LW_W-1:0] cx_r, cy_r;
  logic [LEN2_W-1:0]       len2_r;
  logic [TGT_W-1:0]        ax_r, ay_r;

  assign dx  = $signed({1'b0, pb_r[31:16]}) - $signed({1'b0, pa_r[31:16]});
  assign dy  = $signed({1'b0, pb_r[15:0]})  - $signed({1'b0, pa_r[15:0]});
  assign dxf = (dx == '0 && dy == '0) ? 17'sd1 : dx;

  always_ff @(posedge clk) begin
    if (cmd_i.cap_i) begin
      dxp_r <= dxf > 0;
      dxn_r <= dxf < 0;
      dyp_r <= dy > 0;
      dyn_r <= dy < 0;
      adx_r <= COORD_W'(dxf < 0 ? -dxf : dxf);
      ady_r <= COORD_W'(dy < 0 ? -dy : dy);
    end
    if (cmd_i.sq) begin
      adx2_r <= adx_r * adx_r;
      ady2_r <= ady_r * ady_r;
      cx_r   <= ady_r * lw_r;
      cy_r   <= adx_r * lw_r;
    end
    if (cmd_i.len) begin
      len2_r <= LEN2_W'(adx2_r) + LEN2_W'(ady2_r);
      ax_r   <= cx_r * cx_r;
      ay_r   <= cy_r * cy_r;
    end
  end

  // offset search: largest k with (2k-1)^2 * len2 <= target
  logic [K_W-1:0]   cur_r, bit_r, kx_r, ky_r, kk, cur_new;
  logic             sel_r;
  logic [T_W-1:0]   tt;
  logic [T2_W-1:0]  t2_r;
  logic [38:0]      plo_r;
  logic [37:0]      phi_r;
  logic [PROD_W-1:0] prod;
  logic [TGT_W-1:0] tgt;

  assign kk      = cur_r | bit_r;
  assign tt      = {kk, 1'b0} - T_W'(1);
  assign prod    = PROD_W'(plo_r) + PROD_W'({phi_r, 17'b0});
  assign tgt     = sel_r ? ay_r : ax_r;
  assign cur_new = (prod <= PROD_W'(tgt)) ? kk : cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
      sel_r <= 1'b0;
    end else if (cmd_i.len) begin
      bit_r <= {1'b1, {(K_W-1){1'b0}}};
      sel_r <= 1'b0;
    end else if (cmd_i.k_cmp) begin
      if (bit_r[0]) begin
        bit_r <= {1'b1, {(K_W-1){1'b0}}};
        sel_r <= 1'b1;
      end else begin
        bit_r <= bit_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.len) cur_r <= '0;
    if (cmd_i.k_t)  t2_r  <= tt * tt;
    if (cmd_i.k_m0) plo_r <= t2_r * len2_r[16:0];
    if (cmd_i.k_m1) phi_r <= t2_r * len2_r[32:17];
    if (cmd_i.k_cmp) begin
      if (bit_r[0]) begin
        cur_r <= '0;
        if (sel_r) ky_r <= cur_new;
        else kx_r <= cur_new;
      end else begin
        cur_r <= cur_new;
      end
    end
  end

  // vertices and output register
  logic signed [K_W+1:0]  ox, oy;
  logic signed [17:0]     vx, vy;
  logic                   out_valid_r, out_free;
  logic [COORD_W-1:0]     ovx_r, ovy_r;
  logic [VNUM_W-1:0]      vn_r, ovn_r;
  logic                   olast_r;

  assign ox = dyp_r ? -$signed({2'b0, kx_r}) : (dyn_r ? $signed({2'b0, kx_r}) : '0);
  assign oy = dxp_r ? $signed({2'b0, ky_r}) : (dxn_r ? -$signed({2'b0, ky_r}) : '0);
  assign vx = cmd_i.emit_m ? $signed({2'b0, pi_r[31:16]}) - 18'(ox)
                           : $signed({2'b0, pi_r[31:16]}) + 18'(ox);
  assign vy = cmd_i.emit_m ? $signed({2'b0, pi_r[15:0]}) - 18'(oy)
                           : $signed({2'b0, pi_r[15:0]}) + 18'(oy);
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vn_r        <= '0;
    end else begin
      if (cmd_i.emit_p || cmd_i.emit_m) begin
        out_valid_r <= 1'b1;
        vn_r        <= vn_r + VNUM_W'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_i.chk) vn_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit_p || cmd_i.emit_m) begin
      ovx_r   <= sat16(vx);
      ovy_r   <= sat16(vy);
      ovn_r   <= vn_r;
      olast_r <= cmd_i.emit_m && idx_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b0, ovn_r, ovy_r, ovx_r};
  assign out_tlast  = olast_r;

  assign stat_o.n_ok     = (n_r >= CNT_W'(2)) && (bw_r != '0) && (bh_r != '0);
  assign stat_o.div_done = div_done;
  assign stat_o.idx_last = idx_last;
  assign stat_o.bit_last = bit_r[0];
  assign stat_o.sel_y    = sel_r;
  assign stat_o.out_free = out_free;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit_p || cmd_i.emit_m) |-> out_free)
    else $error("vertex loaded over a pending one");
  a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bit_r))
    else $error("search bit not one-hot");
  a_pt_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pt_wr |-> (CNT_W'(idx_r) < n_r))
    else $error("point written beyond the set");
endmodule
`default_nettype wire

// ===== hdl/pst_ctrl.sv =====
// ---------------------------------------------------------------------------
// pst_ctrl: sequencer of the stroke tessellator
// Loads samples, runs the fitting pass, then the offset pass per point.
// ---------------------------------------------------------------------------
`default_nettype none
module pst_ctrl
  import pst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_tlast,
  output logic           in_tready,
  input  wire pst_stat_t stat_i,
  output pst_cmd_t       cmd_o
);
  pst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    cmd_o.rd_sel  = RD_I;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          if (in_tlast) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.n_ok) begin
          cmd_o.chk     = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_nxt     = ST_XGO;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_XGO: begin
        cmd_o.xdiv_go = 1'b1;
        state_nxt     = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.x_cap = 1'b1;
          state_nxt   = ST_YGO;
        end
      end
      ST_YGO: begin
        cmd_o.ydiv_go = 1'b1;
        state_nxt     = ST_YWAIT;
      end
      ST_YWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.y_cap = 1'b1;
          state_nxt   = ST_PTWR;
        end
      end
      ST_PTWR: begin
        cmd_o.pt_wr = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_nxt     = ST_RDA;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_nxt     = ST_XGO;
        end
      end
      ST_RDA: begin
        cmd_o.rd_sel = RD_A;
        state_nxt    = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.rd_sel = RD_B;
        cmd_o.cap_a  = 1'b1;
        state_nxt    = ST_RDI;
      end
      ST_RDI: begin
        cmd_o.rd_sel = RD_I;
        cmd_o.cap_b  = 1'b1;
        state_nxt    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.cap_i = 1'b1;
        state_nxt   = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq  = 1'b1;
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        cmd_o.len = 1'b1;
        state_nxt = ST_KT;
      end
      ST_KT: begin
        cmd_o.k_t = 1'b1;
        state_nxt = ST_KM0;
      end
      ST_KM0: begin
        cmd_o.k_m0 = 1'b1;
        state_nxt  = ST_KM1;
      end
      ST_KM1: begin
        cmd_o.k_m1 = 1'b1;
        state_nxt  = ST_KCMP;
      end
      ST_KCMP: begin
        cmd_o.k_cmp = 1'b1;
        if (stat_i.bit_last && stat_i.sel_y) state_nxt = ST_EMITP;
        else state_nxt = ST_KT;
      end
      ST_EMITP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_p = 1'b1;
          state_nxt    = ST_EMITM;
        end
      end
      ST_EMITM: begin
        if (stat_i.out_free) begin
          cmd_o.emit_m = 1'b1;
          if (stat_i.idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_nxt     = ST_RDA;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/polyline_stroke_tessellator_unit.sv =====
// ---------------------------------------------------------------------------
// polyline_stroke_tessellator_unit: sparkline samples to a stroked strip
// Collects a set of samples, fits them into the box and emits two
// offset vertices per point as a triangle strip.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  in_     | in  | tvalid/tready      | tdata: sample_value; tlast: end_of_set
//  out_    | out | tvalid/tready      | tdata: x, y, vertex_number; tlast: last
//  cfg_    | in  | valid/ready        | index 0 box_width, 1 box_height,
//          |     |                    |   2 line_width; data
//
//  A sample is taken in any idle cycle that offers one. The marked sample
//  starts tessellation, during which input is held off: per point, fitting
//  (two divider passes, each a start, 35 quotient steps and a capture, and
//  one point write) and offset work (point reads and squares, two 10-bit
//  searches of a square, two products and a compare per bit, two emits).
//  Reset: synchronous rst_n; registers return to 100/40/16, counts clear.
//  The stores need no clearing pass. Output back-pressure stalls the
//  sequencer only at vertex hand-off; the next set loads while the last
//  vertex waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module polyline_stroke_tessellator_unit
  import pst_pkg::*;
#(
  parameter int MAX_SAMPLES = 32
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [15:0]          in_tdata,   // [15:0] sample_value
  input  wire logic                 in_tlast,   // end_of_set
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata,  // [15:0] x, [31:16] y, [37:32] number
  output logic                      out_tlast,  // last_vertex
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BOX_W-1:0]     cfg_data
);
  pst_cmd_t  cmd;
  pst_stat_t stat;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pst_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule
`default_nettype wire

// ===== bench/pst_checker.sv =====
// ---------------------------------------------------------------------------
// pst_checker: vertex predictor and scoreboard for the stroke tessellator
// Watches the sample, vertex and register channels, computes the strip
// each finished set should produce and compares every vertex in order.
// ---------------------------------------------------------------------------
module pst_checker
  import pst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOX_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   vertices_due
);

  localparam int DEPTH = 32;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [5:0]  num;
    logic        last;
  } vertex_t;

  vertex_t     strip_q[$];
  logic [15:0] samples[DEPTH];
  logic [15:0] pts_x[DEPTH];
  logic [15:0] pts_y[DEPTH];
  int          n_samples;
  longint      lowest, highest;
  int unsigned box_w, box_h, stroke_w;

  assign vertices_due = strip_q.size();

  function automatic longint unsigned div_near(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // nearest k with k ~ comp*lw / (2*sqrt(len2)), bitwise search on 10 bits
  function automatic longint unsigned offset_mag(longint unsigned comp,
                                                 longint unsigned len2, int unsigned lw);
    longint unsigned tgt, k, cand, t;
    tgt = comp * comp * lw * lw;
    k = 0;
    for (int b = 9; b >= 0; b--) begin
      cand = k | (64'd1 << b);
      t = 2 * cand - 1;
      if (t * t * len2 <= tgt) k = cand;
    end
    return k;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic build_strip();
    int unsigned     uw, uh, a, b;
    longint unsigned span, off, xv, yv, adx, ady, len2, kx, ky;
    longint          s, px, py, dx, dy, ox, oy;
    vertex_t         vp, vm;
    int              n;
    n = n_samples;
    if (n < 2 || box_w == 0 || box_h == 0) return;
    uw = (box_w > 4) ? box_w - 4 : 1;
    uh = (box_h > 6) ? box_h - 6 : 1;
    span = (highest > lowest) ? longint'(highest - lowest) : 1;
    for (int i = 0; i < n; i++) begin
      s = longint'($signed(samples[i]));
      xv = 32 + div_near(16 * i * uw, n - 1);
      off = div_near(16 * longint'(s - lowest) * uh, span);
      yv = 48 + 16 * uh - off;
      pts_x[i] = xv[15:0];
      pts_y[i] = yv[15:0];
    end
    for (int i = 0; i < n; i++) begin
      // end difference at both ends, central difference inside
      a = (i == 0) ? 0 : ((i == n - 1) ? n - 2 : i - 1);
      b = (i == 0) ? 1 : ((i == n - 1) ? n - 1 : i + 1);
      px = pts_x[i];
      py = pts_y[i];
      dx = longint'(pts_x[b]) - longint'(pts_x[a]);
      dy = longint'(pts_y[b]) - longint'(pts_y[a]);
      if (dx == 0 && dy == 0) dx = 1;   // degenerate direction
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      len2 = adx * adx + ady * ady;
      kx = offset_mag(ady, len2, stroke_w);
      ky = offset_mag(adx, len2, stroke_w);
      ox = (dy > 0) ? -longint'(kx) : ((dy < 0) ? longint'(kx) : 0);
      oy = (dx > 0) ? longint'(ky) : ((dx < 0) ? -longint'(ky) : 0);
      vp = '{clamp16(px + ox), clamp16(py + oy), 6'(2 * i), 1'b0};
      vm = '{clamp16(px - ox), clamp16(py - oy), 6'(2 * i + 1), 1'(i == n - 1)};
      strip_q.push_back(vp);
      strip_q.push_back(vm);
    end
  endtask

  task automatic take_sample(logic [15:0] raw, logic mark);
    longint v;
    v = longint'($signed(raw));
    if (n_samples < DEPTH) begin
      if (n_samples == 0) begin
        lowest = v;
        highest = v;
      end else begin
        if (v < lowest) lowest = v;
        if (v > highest) highest = v;
      end
      samples[n_samples] = raw;
      n_samples++;
    end
    if (mark) begin
      build_strip();
      n_samples = 0;
    end
  endtask

  task automatic match_vertex(vertex_t got);
    vertex_t want;
    if (strip_q.size() == 0) begin
      $error("unexpected vertex x=%0d y=%0d num=%0d", $signed(got.x), $signed(got.y),
             got.num);
      fail_count++;
      return;
    end
    want = strip_q.pop_front();
    if (got.x !== want.x) begin
      $error("vertex_x exp %0d got %0d", $signed(want.x), $signed(got.x));
      fail_count++;
    end
    if (got.y !== want.y) begin
      $error("vertex_y exp %0d got %0d", $signed(want.y), $signed(got.y));
      fail_count++;
    end
    if (got.num !== want.num) begin
      $error("vertex_number exp %0d got %0d", want.num, got.num);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last_vertex exp %0d got %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    n_samples = 0;
    lowest = 0;
    highest = 0;
    box_w = 100;
    box_h = 40;
    stroke_w = 16;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BOX_WIDTH:  box_w = cfg_data;
          CFG_BOX_HEIGHT: box_h = cfg_data;
          CFG_LINE_WIDTH: stroke_w = cfg_data[LW_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        match_vertex('{out_tdata[15:0], out_tdata[31:16], out_tdata[37:32], out_tlast});
    end
  end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: stroke tessellator testbench top
// Drives sample sets and register writes under varying idle and stall
// patterns; the checker predicts and compares, this top gives the verdict.
// ---------------------------------------------------------------------------
module tb;
  import pst_pkg::*;

  localparam int HALF_HI = 6;
  localparam int HALF_LO = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // index with no register

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;   // [15:0] sample_value
  logic                 in_tlast = 1'b0; // end_of_set
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;       // [15:0] x, [31:16] y, [37:32] number
  logic                 out_tlast;       // last_vertex
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BOX_WIDTH;
  logic [BOX_W-1:0]     cfg_data = '0;

  int   fail_count, vertices_due;
  int   send_idle = 0;    // percent of cycles the sender sits out
  int   recv_stall = 0;   // percent of cycles the receiver stalls
  logic hold_rx = 1'b0;   // long receiver hold-off

  always begin
    #HALF_HI clk = 1'b1;
    #HALF_LO clk = 1'b0;
  end

  polyline_stroke_tessellator_unit dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pst_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .vertices_due
  );

  // receiver: random stalls, or a flat hold-off while hold_rx is up
  always @(posedge clk)
    out_tready <= !hold_rx && ($urandom_range(99) >= recv_stall);

  // one sample item; valid stays up between back-to-back items
  task automatic send_item(logic [15:0] v, logic mark);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= mark;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all vertices, then cover a set that produced none
  task automatic settle();
    while (vertices_due != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_box(int w, int h, int lw);
    settle();
    write_reg(CFG_BOX_WIDTH, BOX_W'(w));
    write_reg(CFG_BOX_HEIGHT, BOX_W'(h));
    write_reg(CFG_LINE_WIDTH, BOX_W'(lw));
  endtask

  // a well-formed set: n samples, last one marked; style picks the content
  task automatic send_set(int n, int style);
    logic [15:0] base, v;
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: v = 16'($urandom);
        1: v = base + 16'($urandom_range(0, 40)) - 16'd20;
        default: v = base;
      endcase
      send_item(v, i == n - 1);
    end
    stop_sending();
  endtask

  task automatic random_sets(int quota);
    int got, n, r;
    got = 0;
    while (got < quota) begin
      r = $urandom_range(99);
      if (r < 8) n = 1;
      else if (r < 75) n = $urandom_range(2, 8);
      else if (r < 95) n = $urandom_range(9, 20);
      else n = $urandom_range(31, 35);   // near and past the store depth
      send_set(n, $urandom_range(2));
      got += n;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, extremes, single sample, flat set
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'h1234, 1'b1);      // lone sample: no strip
    send_set(4, 2);                 // equal extremes
    stop_sending();

    // wide box, thick line: coordinates saturate
    set_box(4095, 4095, 1023);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b1);
    stop_sending();

    // one-pixel box, zero width: the strip collapses onto the points;
    // 34 samples so the store overflows and the marked one is dropped
    set_box(1, 1, 0);
    send_set(34, 2);

    // zero box emits nothing; write the unused index once
    set_box(0, 0, 500);
    send_set(3, 0);
    settle();
    write_reg(CFG_SPARE, 12'hFFF);

    // random phases: sender idle / receiver stall mixes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 4 == 3) set_box(4095, 1, $urandom_range(0, 1023));
      else set_box($urandom_range(1, 300), $urandom_range(1, 120), $urandom_range(0, 1023));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 45; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 45; end
        default: begin send_idle = 6; recv_stall = 6; end
      endcase
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps offering sets
        send_idle = 0;
        fork
          begin
            hold_rx <= 1'b1;
            repeat (800) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      random_sets(12);
    end

    while (vertices_due != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== polyline_stroke_tessellator_unit.f =====
hdl/pst_pkg.sv
hdl/pst_div.sv
hdl/pst_dp.sv
hdl/pst_ctrl.sv
hdl/polyline_stroke_tessellator_unit.sv
bench/pst_checker.sv
bench/tb.sv
